>>> rtl/assert_macros.svh
// Assertion macros shared by the shuffled Lehmer generator RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/slrg_pkg.sv
// Package for the shuffled Lehmer generator: sizes, constants, FSM state type
// and the command/status structs between controller and datapath. No dependencies.
package slrg_pkg;

  localparam int unsigned TableDepth  = 32;
  localparam int unsigned WarmupSteps = 8;
  localparam int unsigned StepCount   = TableDepth + WarmupSteps;
  localparam int unsigned IdxW        = $clog2(TableDepth);
  localparam int unsigned CntW        = $clog2(StepCount);
  localparam int unsigned ValW        = 31;
  localparam int unsigned MulW        = 15;
  localparam int unsigned ProdW       = ValW + MulW;

  localparam logic [ValW-1:0] LehmerMod  = 31'h7FFF_FFFF;
  localparam logic [MulW-1:0] LehmerMul  = 15'd16807;
  localparam logic [ValW-1:0] ClampLimit = 31'd2147483389;
  localparam logic [ValW-1:0] SeedOne    = 31'd1;
  // Divisor that maps the shuffle output onto a table slot
  localparam longint unsigned SlotDiv = 64'd1 + (64'd2147483646 / TableDepth);

  // Request codes carried by the opcode field
  typedef enum logic {
    OP_NEXT   = 1'b0,
    OP_RESEED = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP_MUL,
    ST_STEP_RED,
    ST_DRAW_MUL,
    ST_DRAW_RED
  } state_t;

  typedef struct packed {
    logic            load_seed;
    logic            seed_given;
    logic            step_load;
    logic            warm_wr;
    logic [IdxW-1:0] warm_idx;
    logic            seed_done;
    logic            draw_commit;
  } slrg_cmd_t;

  typedef struct packed {
    logic seeded;
    logic out_free;
  } slrg_sts_t;

endpackage

>>> rtl/slrg_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependencies.
module slrg_ram #(
  parameter int unsigned Width = 31,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/slrg_datapath.sv
// Datapath: Lehmer state, registered multiply, Mersenne fold, shuffle table,
// shuffle output and result register. Depends on slrg_pkg and slrg_ram.
`include "assert_macros.svh"

module slrg_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  slrg_pkg::slrg_cmd_t          cmd,
  output slrg_pkg::slrg_sts_t          sts,
  input  logic [slrg_pkg::ValW-1:0]    seed_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [slrg_pkg::ValW-1:0]    out_random_value,
  output logic                         out_clamped
);

  logic [slrg_pkg::ValW-1:0]  x_r, x_nxt;
  logic [slrg_pkg::ProdW-1:0] prod_r;
  logic [slrg_pkg::ValW-1:0]  shout_r, shout_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [slrg_pkg::ValW-1:0]  out_value_r;
  logic                       out_clamped_r;
  logic [slrg_pkg::ValW-1:0]  seed_fix;
  logic [slrg_pkg::ValW:0]    fold_sum;
  logic [slrg_pkg::ValW-1:0]  x_red;
  logic [slrg_pkg::ValW-1:0]  slot_q;
  logic [slrg_pkg::IdxW-1:0]  slot;
  logic                       ram_wr_en;
  logic [slrg_pkg::IdxW-1:0]  ram_wr_addr;
  logic [slrg_pkg::ValW-1:0]  ram_rd_data;

  // Seed with one on a first plain request, or when the seed is zero or all ones
  assign seed_fix = (!cmd.seed_given || (seed_value == '0) ||
                     (seed_value == slrg_pkg::LehmerMod)) ?
                    slrg_pkg::SeedOne : seed_value;

  // Fold the product modulo 2^31-1: high part plus low part, one subtract
  assign fold_sum = {1'b0, prod_r[slrg_pkg::ValW-1:0]} +
                    (slrg_pkg::ValW+1)'(prod_r[slrg_pkg::ProdW-1:slrg_pkg::ValW]);
  assign x_red = (fold_sum >= {1'b0, slrg_pkg::LehmerMod}) ?
                 slrg_pkg::ValW'(fold_sum - {1'b0, slrg_pkg::LehmerMod}) :
                 fold_sum[slrg_pkg::ValW-1:0];

  // Table slot from the current shuffle output
  assign slot_q = slrg_pkg::ValW'(shout_r / slrg_pkg::SlotDiv);
  assign slot   = slot_q[slrg_pkg::IdxW-1:0];

  // Next values of the generator state and shuffle output
  always_comb begin
    x_nxt = x_r;
    if (cmd.load_seed) begin
      x_nxt = seed_fix;
    end else if (cmd.step_load || cmd.draw_commit) begin
      x_nxt = x_red;
    end
  end

  always_comb begin
    shout_nxt = shout_r;
    if (cmd.seed_done) begin
      shout_nxt = x_red;
    end else if (cmd.draw_commit) begin
      shout_nxt = ram_rd_data;
    end
  end

  // Result register: load on commit, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.draw_commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r         <= slrg_pkg::SeedOne;
      shout_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      x_r         <= x_nxt;
      shout_r     <= shout_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Multiply the state every cycle; the fold consumes the product in the next cycle
  always_ff @(posedge clk) begin
    prod_r <= slrg_pkg::ProdW'(x_r) * slrg_pkg::ProdW'(slrg_pkg::LehmerMul);
  end

  always_ff @(posedge clk) begin
    if (cmd.draw_commit) begin
      out_value_r   <= ram_rd_data;
      out_clamped_r <= (ram_rd_data > slrg_pkg::ClampLimit);
    end
  end

  // Shuffle table: warm-up fill or swap-in of the fresh state
  assign ram_wr_en   = cmd.warm_wr || cmd.draw_commit;
  assign ram_wr_addr = cmd.draw_commit ? slot : cmd.warm_idx;

  slrg_ram #(
    .Width (slrg_pkg::ValW),
    .Depth (slrg_pkg::TableDepth)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (x_red),
    .rd_addr (slot),
    .rd_data (ram_rd_data)
  );

  assign sts.seeded   = (shout_r != '0);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_random_value = out_value_r;
  assign out_clamped      = out_clamped_r;

  `ASSERT_NEXT(a_seed_nonzero, cmd.seed_done, shout_r != '0)
  `ASSERT_NEXT(a_state_nonzero, cmd.step_load || cmd.draw_commit, x_r != '0)
  `ASSERT_IMPLY(a_out_hold, out_valid_r && !out_ready, !cmd.draw_commit)

endmodule

>>> rtl/slrg_ctrl.sv
// Controller FSM: accepts requests, sequences the warm-up steps and the draw.
// Depends on slrg_pkg.
`include "assert_macros.svh"

module slrg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_opcode,
  input  slrg_pkg::slrg_sts_t sts,
  output slrg_pkg::slrg_cmd_t cmd
);

  slrg_pkg::state_t          state_r, state_nxt;
  logic [slrg_pkg::CntW-1:0] cnt_r, cnt_nxt;
  logic                      accept;
  logic                      reseed_req;
  logic                      need_seed;
  logic                      last_step;

  assign accept     = in_valid && in_ready;
  assign reseed_req = (in_opcode == slrg_pkg::OP_RESEED);
  assign need_seed  = reseed_req || !sts.seeded;
  assign last_step  = (cnt_r == '0);

  // Next state and step counter
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      slrg_pkg::ST_IDLE: begin
        if (accept) begin
          if (need_seed) begin
            state_nxt = slrg_pkg::ST_STEP_MUL;
            cnt_nxt   = slrg_pkg::CntW'(slrg_pkg::StepCount - 1);
          end else begin
            state_nxt = slrg_pkg::ST_DRAW_RED;
          end
        end
      end
      slrg_pkg::ST_STEP_MUL: state_nxt = slrg_pkg::ST_STEP_RED;
      slrg_pkg::ST_STEP_RED: begin
        if (last_step) begin
          state_nxt = slrg_pkg::ST_DRAW_MUL;
        end else begin
          state_nxt = slrg_pkg::ST_STEP_MUL;
          cnt_nxt   = cnt_r - 1'b1;
        end
      end
      slrg_pkg::ST_DRAW_MUL: state_nxt = slrg_pkg::ST_DRAW_RED;
      slrg_pkg::ST_DRAW_RED: begin
        if (sts.out_free) begin
          state_nxt = slrg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = slrg_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    in_ready        = 1'b0;
    cmd             = '0;
    cmd.warm_idx    = cnt_r[slrg_pkg::IdxW-1:0];
    case (state_r)
      slrg_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.load_seed  = in_valid && need_seed;
        cmd.seed_given = reseed_req;
      end
      slrg_pkg::ST_STEP_RED: begin
        cmd.step_load = 1'b1;
        cmd.warm_wr   = (cnt_r < slrg_pkg::CntW'(slrg_pkg::TableDepth));
        cmd.seed_done = last_step;
      end
      slrg_pkg::ST_DRAW_RED: begin
        cmd.draw_commit = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slrg_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `ASSERT_IMPLY(a_commit_free, cmd.draw_commit, sts.out_free)
  `ASSERT_NEXT(a_seed_starts, accept && need_seed, state_r == slrg_pkg::ST_STEP_MUL)
  `ASSERT_NEXT(a_warm_ends, cmd.seed_done, state_r == slrg_pkg::ST_DRAW_MUL)

endmodule

>>> rtl/shuffled_lehmer_random_generator_unit.sv
// Shuffled Lehmer generator (minimal-standard multiplier 16807 modulo 2^31-1
// with a 32-entry shuffle table). Each generator step is a registered 31x15
// multiply followed by a fold-and-subtract modulo 2^31-1. A next-number
// request is accepted in the idle state and goes straight to the draw-reduce
// state; its result item is then presented from the result register. A reseed
// request, or the first request after reset, runs 40 warm-up steps, each a
// multiply state and a reduce state, and then a draw through the draw-multiply
// and draw-reduce states. The draw waits while an earlier result item is still
// held, and a new request is taken once the draw has been committed to the
// result register. Top level; depends on slrg_pkg, slrg_ctrl and slrg_datapath.
module shuffled_lehmer_random_generator_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_opcode,
  input  logic [slrg_pkg::ValW-1:0] in_seed_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [slrg_pkg::ValW-1:0] out_random_value,
  output logic                      out_clamped
);

  slrg_pkg::slrg_cmd_t cmd;
  slrg_pkg::slrg_sts_t sts;

  slrg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .sts       (sts),
    .cmd       (cmd)
  );

  slrg_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .seed_value       (in_seed_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_random_value (out_random_value),
    .out_clamped      (out_clamped)
  );

endmodule

>>> tb/shuffled_lehmer_random_generator_unit_test.sv
// Testbench for shuffled_lehmer_random_generator_unit: drives next and reseed requests,
// predicts each draw with its own Lehmer/shuffle model and checks every result item.
// Depends on slrg_pkg and the unit itself.
module shuffled_lehmer_random_generator_unit_test;

  localparam int unsigned RandomItems   = 1530;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned IdlePercent   = 29;

  // Predicted generator: own copy of the Lehmer state, the shuffle table and the last draw
  class lehmer_draw_scoreboard;
    typedef struct {
      logic [slrg_pkg::ValW-1:0] value;
      logic                      clamped;
    } draw_t;

    logic [slrg_pkg::ValW-1:0] gen_state;
    logic [slrg_pkg::ValW-1:0] last_draw;
    logic [slrg_pkg::ValW-1:0] slots [slrg_pkg::TableDepth];
    draw_t                     expected_draws [$];
    int unsigned               mismatches;

    function new();
      gen_state   = slrg_pkg::SeedOne;
      last_draw   = '0;
      mismatches  = 0;
      foreach (slots[n]) slots[n] = '0;
    endfunction

    function logic [slrg_pkg::ValW-1:0] lehmer_step(logic [slrg_pkg::ValW-1:0] x);
      return slrg_pkg::ValW'((64'(x) * 64'(slrg_pkg::LehmerMul)) %
                             64'(slrg_pkg::LehmerMod));
    endfunction

    // Load the seed, run the warm-up and fill the table, last value in slot 0
    function void reseed(logic [slrg_pkg::ValW-1:0] seed);
      logic [slrg_pkg::ValW-1:0] x;
      x = (seed == '0 || seed == slrg_pkg::LehmerMod) ? slrg_pkg::SeedOne : seed;
      for (int n = slrg_pkg::StepCount - 1; n >= 0; n--) begin
        x = lehmer_step(x);
        if (n < slrg_pkg::TableDepth) slots[n] = x;
      end
      gen_state = x;
      last_draw = slots[0];
    endfunction

    // Advance the generator for one accepted request and queue the draw it produces
    function void note_request(slrg_pkg::opcode_t op, logic [slrg_pkg::ValW-1:0] seed);
      int unsigned slot;
      draw_t       d;
      if (op == slrg_pkg::OP_RESEED) reseed(seed);
      else if (last_draw == '0) reseed(slrg_pkg::SeedOne);
      gen_state = lehmer_step(gen_state);
      slot = int'((64'(last_draw) / slrg_pkg::SlotDiv) % slrg_pkg::TableDepth);
      last_draw = slots[slot];
      slots[slot] = gen_state;
      d.value   = last_draw;
      d.clamped = (last_draw > slrg_pkg::ClampLimit);
      expected_draws.push_back(d);
    endfunction

    function int unsigned pending();
      return expected_draws.size();
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // Compare one result item with the oldest predicted draw
    task check_draw(logic [slrg_pkg::ValW-1:0] value, logic clamped);
      draw_t want;
      if (expected_draws.size() == 0) begin
        report_mismatch($sformatf("unexpected draw %0d", value));
        return;
      end
      want = expected_draws.pop_front();
      if (value !== want.value)
        report_mismatch($sformatf("random_value %0d, want %0d", value, want.value));
      if (clamped !== want.clamped)
        report_mismatch($sformatf("clamped %0b, want %0b (value %0d)",
                                  clamped, want.clamped, want.value));
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_opcode;
  logic [slrg_pkg::ValW-1:0] in_seed_value;
  logic                      out_valid;
  logic                      out_ready;
  logic [slrg_pkg::ValW-1:0] out_random_value;
  logic                      out_clamped;

  logic                      idle_on;
  int unsigned               hold_offs_asked;
  lehmer_draw_scoreboard     sb;

  shuffled_lehmer_random_generator_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_seed_value    (in_seed_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_random_value (out_random_value),
    .out_clamped      (out_clamped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Multiply modulo 2^31-1
  function automatic logic [slrg_pkg::ValW-1:0] mod_mul(logic [slrg_pkg::ValW-1:0] a,
                                                        logic [slrg_pkg::ValW-1:0] b);
    return slrg_pkg::ValW'((64'(a) * 64'(b)) % 64'(slrg_pkg::LehmerMod));
  endfunction

  function automatic logic [slrg_pkg::ValW-1:0] mod_pow(logic [slrg_pkg::ValW-1:0] base,
                                                        int unsigned power);
    logic [slrg_pkg::ValW-1:0] acc;
    acc = slrg_pkg::SeedOne;
    while (power != 0) begin
      if (power & 1) acc = mod_mul(acc, base);
      base  = mod_mul(base, base);
      power = power >> 1;
    end
    return acc;
  endfunction

  // Find a seed whose first draw after reseeding lands in [lo, hi]: the draw is
  // table slot j, so walk back 40-j steps from the wanted value and require
  // that slot 0 then picks slot j.
  function automatic logic [slrg_pkg::ValW-1:0] seed_for_draw(
      logic [slrg_pkg::ValW-1:0] lo, logic [slrg_pkg::ValW-1:0] hi);
    logic [31:0]               v;
    int unsigned               j;
    logic [slrg_pkg::ValW-1:0] slot0;
    for (v = 32'(lo); v <= 32'(hi); v++) begin
      slot0 = v[slrg_pkg::ValW-1:0];
      for (j = 0; j < slrg_pkg::TableDepth; j++) begin
        if (64'(slot0) / slrg_pkg::SlotDiv == j)
          return mod_mul(v[slrg_pkg::ValW-1:0],
                         mod_pow(slrg_pkg::ValW'(slrg_pkg::LehmerMul),
                                 32'(slrg_pkg::LehmerMod) - 1 -
                                 (slrg_pkg::StepCount - j)));
        slot0 = mod_mul(slot0, slrg_pkg::ValW'(slrg_pkg::LehmerMul));
      end
    end
    return slrg_pkg::SeedOne;
  endfunction

  // Offer one request; hold it until accepted
  task automatic send_request(slrg_pkg::opcode_t op, logic [slrg_pkg::ValW-1:0] seed);
    if (idle_on && $urandom_range(99) < IdlePercent) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IdlePercent);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_seed_value <= seed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off whenever one is asked for
  initial begin : receiver
    int unsigned served;
    served    = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_offs_asked != served) begin
        served = hold_offs_asked;
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end
      out_ready <= idle_on ? ($urandom_range(99) >= IdlePercent) : 1'b1;
    end
  end

  // Note accepted requests and check accepted result items
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_request(slrg_pkg::opcode_t'(in_opcode), in_seed_value);
    if (rst_n && out_valid && out_ready) sb.check_draw(out_random_value, out_clamped);
  end

  initial begin
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [slrg_pkg::ValW-1:0] hot_seed;
    logic [slrg_pkg::ValW-1:0] near_seed;
    logic [slrg_pkg::ValW-1:0] seed;
    slrg_pkg::opcode_t         op;
    sb              = new();
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_opcode       = slrg_pkg::OP_NEXT;
    in_seed_value   = '0;
    idle_on         = 1'b1;
    hold_offs_asked = 0;
    hot_seed  = seed_for_draw(slrg_pkg::ClampLimit + 31'd1, slrg_pkg::LehmerMod - 31'd1);
    near_seed = seed_for_draw(slrg_pkg::ClampLimit - 31'd300, slrg_pkg::ClampLimit);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // First request after reset is a plain next: the block seeds itself with one
    send_request(slrg_pkg::OP_NEXT, 31'h1234_5678);
    send_request(slrg_pkg::OP_NEXT, 31'($urandom()));
    send_request(slrg_pkg::OP_NEXT, '0);
    // Zero seed and all-ones seed both fall back to one
    send_request(slrg_pkg::OP_RESEED, '0);
    send_request(slrg_pkg::OP_NEXT, 31'($urandom()));
    send_request(slrg_pkg::OP_RESEED, 31'h7FFF_FFFF);
    send_request(slrg_pkg::OP_NEXT, 31'h7FFF_FFFF);
    send_request(slrg_pkg::OP_RESEED, slrg_pkg::SeedOne);
    send_request(slrg_pkg::OP_RESEED, slrg_pkg::LehmerMod - 31'd1);
    send_request(slrg_pkg::OP_NEXT, '0);
    send_request(slrg_pkg::OP_RESEED, 31'h5555_5555);
    send_request(slrg_pkg::OP_RESEED, 31'h2AAA_AAAA);
    send_request(slrg_pkg::OP_RESEED, 31'h4000_0000);
    // Draw just above the clamp limit, then at or just below it
    send_request(slrg_pkg::OP_RESEED, hot_seed);
    send_request(slrg_pkg::OP_NEXT, '0);
    send_request(slrg_pkg::OP_NEXT, '0);
    send_request(slrg_pkg::OP_RESEED, near_seed);
    send_request(slrg_pkg::OP_NEXT, 31'($urandom()));

    // Random mix, mostly next requests with occasional reseeds
    for (int n = 0; n < RandomItems; n++) begin
      idle_on <= !(n >= 600 && n < 900);
      if (n == 300) hold_offs_asked <= hold_offs_asked + 1;
      op = ($urandom_range(99) < 12) ? slrg_pkg::OP_RESEED : slrg_pkg::OP_NEXT;
      case ($urandom_range(19))
        0:       seed = '0;
        1:       seed = 31'h7FFF_FFFF;
        default: seed = 31'($urandom());
      endcase
      send_request(op, seed);
    end
    in_valid <= 1'b0;

    // Drain outstanding draws, then idle before the verdict
    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
